@@ rtl/cht_pkg.sv @@
// Shared types, codes and defaults for the chained hash table unit.
// No dependencies.
package cht_pkg;

   localparam int unsigned BUCKET_COUNT_DEF = 256;
   localparam int unsigned POOL_ENTRIES_DEF = 1024;
   localparam int unsigned RECORD_WIDTH_DEF = 32;

   localparam logic [63:0] HASH_SEED  = 64'd5381;
   localparam int unsigned HASH_SHIFT = 5;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_FIND   = 2'd1;
   localparam logic [1:0] CMD_DEL    = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_DUP  = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  key_byte;
      logic [31:0] data_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_value;
      logic [10:0] entry_count;
   } rsp_type;

endpackage

@@ rtl/chained_hash_table_unit.sv @@
// Chained hash table unit: djb2 key hashing, bucket chains and entry pool in memories.
// Depends on cht_pkg.
//
// Usage: key bytes arrive one beat each on req_ (valid/ready). A nonzero byte folds
// into the running djb2 hash; the key ends with a zero byte, whose command (add,
// find, delete) runs on the finished hash. Only that beat yields a result beat on
// rsp_: status, stored record on a find hit, entries held.
// Key bytes are taken in S_IDLE. Key-ending beat: S_HEAD reads the bucket head,
// S_WALK reads each chain entry visited in turn through the single read port of
// the entry memories, S_EXEC updates, and S_LINK follows when an add links in
// front of an existing head.
// The result sits in an output register; key bytes of the next key are taken while
// it waits. A further key-ending beat holds in its update step until the previous
// result is taken, so a stalled receiver stops the block without loss.
// Reset empties every bucket (valid bits), sets the running hash to 5381 and marks
// the whole pool free; no clearing pass is needed, entries are handed out from the
// stack of freed entries first and from a fresh counter when the stack is empty.
// BUCKET_COUNT must be a power of two (bucket taken from the low hash bits).
module chained_hash_table_unit #(
   parameter int unsigned BUCKET_COUNT = cht_pkg::BUCKET_COUNT_DEF,
   parameter int unsigned POOL_ENTRIES = cht_pkg::POOL_ENTRIES_DEF,
   parameter int unsigned RECORD_WIDTH = cht_pkg::RECORD_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cht_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cht_pkg::rsp_type rsp_data
);
   import cht_pkg::*;

   localparam int unsigned BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int unsigned IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int unsigned LW = $clog2(POOL_ENTRIES + 1);
   localparam logic [LW-1:0] NIL  = LW'(POOL_ENTRIES);
   localparam logic [LW-1:0] POOL = LW'(POOL_ENTRIES);

   typedef enum logic [2:0] {S_IDLE, S_HEAD, S_WALK, S_EXEC, S_LINK} state_type;

   // memories
   logic [LW-1:0]              head_mem [BUCKET_COUNT];
   logic [63+RECORD_WIDTH:0]   ent_mem  [POOL_ENTRIES];
   logic [LW-1:0]              next_mem [POOL_ENTRIES];
   logic [LW-1:0]              prev_mem [POOL_ENTRIES];
   logic [IW-1:0]              free_mem [POOL_ENTRIES];

   logic [LW-1:0]            head_q, next_q, prev_q;
   logic [63+RECORD_WIDTH:0] ent_q;
   logic [IW-1:0]            free_q;

   logic                     head_we, ent_we, next_we, prev_we, free_we;
   logic [BW-1:0]            head_wa;
   logic [LW-1:0]            head_wd, next_wd, prev_wd;
   logic [IW-1:0]            ent_wa, next_wa, prev_wa, free_wa, ent_ra, free_ra;
   logic [63+RECORD_WIDTH:0] ent_wd;
   logic [IW-1:0]            free_wd;

   // registers
   state_type             state_ff, state_in;
   logic [63:0]           hash_ff, hash_in, op_hash_ff, op_hash_in;
   logic [1:0]            cmd_ff, cmd_in;
   logic [RECORD_WIDTH-1:0] rec_ff, rec_in, found_ff, found_in;
   logic [BW-1:0]         bucket_ff, bucket_in;
   logic [LW-1:0]         head_ff, head_in, hprev_ff, hprev_in, hnext_ff, hnext_in;
   logic [IW-1:0]         hidx_ff, hidx_in, new_ff, new_in;
   logic                  hit_ff, hit_in;
   logic [LW-1:0]         held_ff, held_in, fresh_ff, fresh_in, ftop_ff, ftop_in;
   logic [BUCKET_COUNT-1:0] hvld_ff, hvld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [LW-1:0] head_cur, new_link, ftop_dec;
   logic [IW-1:0] new_idx;
   logic          out_free, pool_full;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pool_full = (fresh_ff == POOL) && (ftop_ff == '0);
   assign new_idx   = (ftop_ff != '0) ? free_q : fresh_ff[IW-1:0];
   assign new_link  = LW'(new_idx);
   assign head_cur  = hvld_ff[bucket_ff] ? head_q : NIL;
   assign ftop_dec  = ftop_ff - LW'(1);
   assign free_ra   = ftop_dec[IW-1:0];

   always_comb begin
      state_in = state_ff;  hash_in = hash_ff;  op_hash_in = op_hash_ff;
      cmd_in = cmd_ff;  rec_in = rec_ff;  found_in = found_ff;  bucket_in = bucket_ff;
      head_in = head_ff;  hprev_in = hprev_ff;  hnext_in = hnext_ff;
      hidx_in = hidx_ff;  new_in = new_ff;  hit_in = hit_ff;
      held_in = held_ff;  fresh_in = fresh_ff;  ftop_in = ftop_ff;  hvld_in = hvld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;  rsp_in = rsp_ff;
      head_we = 1'b0;  head_wa = bucket_ff;  head_wd = NIL;
      ent_we = 1'b0;   ent_wa = new_idx;     ent_wd = {op_hash_ff, rec_ff};
      next_we = 1'b0;  next_wa = new_idx;    next_wd = head_ff;
      prev_we = 1'b0;  prev_wa = new_idx;    prev_wd = NIL;
      free_we = 1'b0;  free_wa = ftop_ff[IW-1:0];  free_wd = hidx_ff;
      ent_ra = head_cur[IW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.key_byte != 8'd0) begin
                  hash_in = (hash_ff << HASH_SHIFT) + hash_ff + 64'(req_data.key_byte);
               end else begin
                  op_hash_in = hash_ff;
                  hash_in    = HASH_SEED;
                  cmd_in     = req_data.command;
                  rec_in     = RECORD_WIDTH'(req_data.data_value);
                  bucket_in  = hash_ff[BW-1:0];
                  state_in   = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            head_in = head_cur;
            hit_in  = 1'b0;
            state_in = (head_cur == NIL) ? S_EXEC : S_WALK;
         end
         S_WALK: begin
            ent_ra = next_q[IW-1:0];
            if (ent_q[63+RECORD_WIDTH:RECORD_WIDTH] == op_hash_ff) begin
               hit_in   = 1'b1;
               hprev_in = prev_q;
               hnext_in = next_q;
               found_in = ent_q[RECORD_WIDTH-1:0];
               state_in = S_EXEC;
            end else if (next_q == NIL) begin
               state_in = S_EXEC;
            end else begin
               hidx_in = next_q[IW-1:0];
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = ST_MISS;
               rsp_in.result_value = '0;
               state_in            = S_IDLE;
               priority if (cmd_ff == CMD_ADD) begin
                  if (hit_ff) begin
                     rsp_in.status = ST_DUP;
                  end else if (pool_full) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     rsp_in.status = ST_OK;
                     ent_we = 1'b1;  next_we = 1'b1;  prev_we = 1'b1;
                     head_we = 1'b1; head_wd = new_link;
                     hvld_in[bucket_ff] = 1'b1;
                     new_in = new_idx;
                     if (ftop_ff != '0) ftop_in = ftop_ff - LW'(1);
                     else               fresh_in = fresh_ff + LW'(1);
                     held_in = held_ff + LW'(1);
                     if (head_ff != NIL) state_in = S_LINK;
                  end
               end else if (cmd_ff == CMD_FIND) begin
                  if (hit_ff) begin
                     rsp_in.status       = ST_OK;
                     rsp_in.result_value = 32'(found_ff);
                  end
               end else if (cmd_ff == CMD_DEL) begin
                  if (hit_ff) begin
                     rsp_in.status = ST_OK;
                     if (hprev_ff != NIL) begin
                        next_we = 1'b1;  next_wa = hprev_ff[IW-1:0];  next_wd = hnext_ff;
                     end else begin
                        head_we = 1'b1;  head_wd = hnext_ff;
                     end
                     if (hnext_ff != NIL) begin
                        prev_we = 1'b1;  prev_wa = hnext_ff[IW-1:0];  prev_wd = hprev_ff;
                     end
                     if (ftop_ff < POOL) begin
                        free_we = 1'b1;
                        ftop_in = ftop_ff + LW'(1);
                     end
                     if (held_ff != '0) held_in = held_ff - LW'(1);
                  end
               end else begin
                  // unused command: nothing changes
                  rsp_in.status = ST_MISS;
               end
               rsp_in.entry_count = 11'(held_in);
            end
         end
         S_LINK: begin
            prev_we  = 1'b1;
            prev_wa  = head_ff[IW-1:0];
            prev_wd  = LW'(new_ff);
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_HEAD) hidx_in = head_cur[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hash_ff      <= HASH_SEED;
         held_ff      <= '0;
         fresh_ff     <= '0;
         ftop_ff      <= '0;
         hvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         held_ff      <= held_in;
         fresh_ff     <= fresh_in;
         ftop_ff      <= ftop_in;
         hvld_ff      <= hvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_hash_ff <= op_hash_in;  cmd_ff <= cmd_in;  rec_ff <= rec_in;
      found_ff <= found_in;  bucket_ff <= bucket_in;  head_ff <= head_in;
      hprev_ff <= hprev_in;  hnext_ff <= hnext_in;  hidx_ff <= hidx_in;
      new_ff <= new_in;  hit_ff <= hit_in;  rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      if (ent_we)  ent_mem[ent_wa]   <= ent_wd;
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (free_we) free_mem[free_wa] <= free_wd;
      head_q <= head_mem[hash_ff[BW-1:0]];
      ent_q  <= ent_mem[ent_ra];
      next_q <= next_mem[ent_ra];
      prev_q <= prev_mem[ent_ra];
      free_q <= free_mem[free_ra];
   end

   // pool accounting: held entries are fresh ones handed out less those on the free stack
   a_pool_count: assert property (@(posedge clock) disable iff (reset)
      held_ff + ftop_ff == fresh_ff)
      else $error("pool accounting broken");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result beat not from update step");

   a_key_end: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.key_byte == 8'd0 |=> state_ff == S_HEAD
         && hash_ff == HASH_SEED)
      else $error("key end did not start lookup");

   a_link_after_add: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LINK |-> $past(state_ff == S_EXEC) && cmd_ff == CMD_ADD)
      else $error("back link outside add");

endmodule

@@ verif/chained_hash_table_checker.sv @@
// Watches the request and response channels of the chained hash table unit,
// keeps its own copy of the table and compares every response beat.
// Depends on cht_pkg.
module chained_hash_table_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  cht_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  cht_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import cht_pkg::*;

   localparam int BUCKETS = BUCKET_COUNT_DEF;
   localparam int POOL    = POOL_ENTRIES_DEF;

   logic [63:0] running_hash;
   int          bucket_head [BUCKETS];
   logic [63:0] slot_hash [POOL];
   logic [31:0] slot_record [POOL];
   int          slot_next [POOL];
   int          slot_prev [POOL];
   int          free_slots [$];
   int          held;
   rsp_type     expected_rsp [$];

   assign pending_count = expected_rsp.size();

   function automatic int chain_find(int b, logic [63:0] h);
      int e;
      e = bucket_head[b];
      while (e < POOL) begin
         if (slot_hash[e] == h) return e;
         e = slot_next[e];
      end
      return POOL;
   endfunction

   task automatic table_apply(req_type r);
      logic [63:0] h;
      int          b, hit, e, p, n;
      rsp_type     res;
      if (r.key_byte != 8'd0) begin
         running_hash = running_hash * 33 + r.key_byte;
         return;
      end
      h = running_hash;
      running_hash = HASH_SEED;
      b = int'(h % BUCKETS);
      hit = chain_find(b, h);
      res = '0;
      res.status = ST_MISS;
      case (r.command)
         CMD_ADD: begin
            if (hit < POOL) res.status = ST_DUP;
            else if (free_slots.size() == 0) res.status = ST_FULL;
            else begin
               e = free_slots.pop_back();
               slot_hash[e] = h;
               slot_record[e] = r.data_value;
               slot_next[e] = bucket_head[b];
               slot_prev[e] = POOL;
               if (bucket_head[b] < POOL) slot_prev[bucket_head[b]] = e;
               bucket_head[b] = e;
               held++;
               res.status = ST_OK;
            end
         end
         CMD_FIND: begin
            if (hit < POOL) begin
               res.status = ST_OK;
               res.result_value = slot_record[hit];
            end
         end
         CMD_DEL: begin
            if (hit < POOL) begin
               p = slot_prev[hit];
               n = slot_next[hit];
               if (p < POOL) slot_next[p] = n;
               else bucket_head[b] = n;
               if (n < POOL) slot_prev[n] = p;
               free_slots.push_back(hit);
               held--;
               res.status = ST_OK;
            end
         end
         default: ;
      endcase
      res.entry_count = held[10:0];
      expected_rsp.push_back(res);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         running_hash = HASH_SEED;
         foreach (bucket_head[i]) bucket_head[i] = POOL;
         free_slots.delete();
         for (int i = POOL - 1; i >= 0; i--) free_slots.push_back(i);
         held = 0;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready) table_apply(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response beat %p", rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               if (want.status !== rsp_data.status ||
                   want.result_value !== rsp_data.result_value ||
                   want.entry_count !== rsp_data.entry_count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected st=%0d val=%h cnt=%0d, got st=%0d val=%h cnt=%0d",
                        want.status, want.result_value, want.entry_count,
                        rsp_data.status, rsp_data.result_value, rsp_data.entry_count);
               end
            end
         end
      end
   end
endmodule

@@ verif/tb_chained_hash_table_unit.sv @@
// Top of the chained hash table unit testbench: clock, reset, key stimulus and verdict.
// Depends on cht_pkg, chained_hash_table_unit and chained_hash_table_checker.
module tb_chained_hash_table_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import cht_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count, pending_count;
   int      send_idle = 0, recv_idle = 0;
   logic    hold_req = 1'b0;
   logic    hold_done = 1'b0;
   int      hold_left = 0;
   int      cycle_count = 0;
   byte unsigned key_pool [16][3];

   chained_hash_table_unit dut (.*);
   chained_hash_table_checker checker_i (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver, with a long hold-off stretch when asked
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_req && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= 300;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic send_beat(logic [1:0] cmd, logic [7:0] kb, logic [31:0] dv);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{command: cmd, key_byte: kb, data_value: dv};
      do @(posedge clock); while (!req_ready);
   endtask

   // one whole key: its bytes, then the ending beat carrying the command
   task automatic send_key(int idx, logic [1:0] cmd, logic [31:0] dv);
      for (int i = 0; i < 3; i++)
         if (key_pool[idx][i] != 0)
            send_beat(2'($urandom_range(3)), key_pool[idx][i], $urandom);
      send_beat(cmd, 8'd0, dv);
   endtask

   task automatic random_phase(int n);
      logic [1:0] cmd;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) begin
            // noise: a stray byte, then an ending beat with any command, the unused one included
            send_beat(2'($urandom_range(3)), 8'($urandom_range(1, 255)), $urandom);
            send_beat(2'($urandom_range(3)), 8'd0, $urandom);
         end else begin
            cmd = 2'($urandom_range(2));
            send_key(int'($urandom_range(15)), cmd, $urandom);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < 16; i++)
         for (int j = 0; j < 3; j++)
            key_pool[i][j] = (j < i % 4) ? 8'($urandom_range(1, 255)) : 8'd0;
      key_pool[1][0] = 8'hFF;
      key_pool[2][0] = 8'h01;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty key, each command, duplicate, unused command, head deletion
      send_key(0, CMD_FIND, 32'h0);
      send_key(0, CMD_ADD, 32'hFFFF_FFFF);
      send_key(0, CMD_ADD, 32'h1234_5678);
      send_key(0, CMD_FIND, 32'h0);
      send_key(1, CMD_ADD, 32'h0);
      send_key(2, CMD_ADD, 32'hA5A5_5A5A);
      send_beat(CMD_UNUSED, 8'd0, 32'hFFFF_FFFF);
      send_key(1, CMD_FIND, 32'h0);
      send_key(0, CMD_DEL, 32'h0);
      send_key(0, CMD_DEL, 32'h0);
      send_key(0, CMD_FIND, 32'h0);
      send_key(2, CMD_DEL, 32'h0);
      send_key(2, CMD_FIND, 32'h0);
      // long hold-off while the sender keeps going
      hold_req <= 1'b1;
      send_key(3, CMD_ADD, 32'h5555_AAAA);
      for (int i = 4; i < 16; i++) send_key(i, CMD_ADD, $urandom);
      send_idle = 7; recv_idle = 45;
      random_phase(70);
      send_idle = 45; recv_idle = 7;
      random_phase(70);
      send_idle = 0; recv_idle = 0;
      random_phase(70);
      random_phase(30);
      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (1100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
